// File: hdl/mbe_pkg.sv
// shared types and constants for the mandelbrot escape-time core
// no dependencies
`timescale 1ns / 1ps

package mbe_pkg;

    // fixed widths of the external fields
    localparam int IN_W      = 32;   // c_real / c_imag width
    localparam int IN_FRAC   = 28;   // fraction bits of the incoming points
    localparam int CFG_W     = 12;   // max_iterations register width
    localparam int CNT_OUT_W = 12;   // iteration_count width

    // shared multiplier consumes the second operand in chunks of this width
    localparam int MUL_CHUNK = 32;

    // escape threshold is 4 = 2^ESC_LOG2 in magnitude squared
    localparam int ESC_LOG2 = 2;

    localparam logic [CFG_W-1:0] RESET_ITERATIONS = CFG_W'(550);

    // control from the top level into the iteration engine
    typedef struct packed {
        logic start;   // point transaction accepted
        logic take;    // finished result moved to the output register
    } t_iter_ctl;

    // status from the iteration engine back to the top level
    typedef struct packed {
        logic idle;        // ready for a new point
        logic res_valid;   // result waiting to be taken
    } t_iter_stat;

    // one finished result
    typedef struct packed {
        logic [CNT_OUT_W-1:0] count;
        logic                 escaped;
    } t_iter_res;

endpackage

// File: hdl/mbe_if.sv
// channel interfaces: point input, result output and configuration write
// depends on nothing; widths match the fields of mbe_pkg
`timescale 1ns / 1ps

interface mbe_point_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] c_real;
    logic signed [31:0] c_imag;

    modport source (output valid, output c_real, output c_imag, input ready);
    modport sink   (input valid, input c_real, input c_imag, output ready);
endinterface

interface mbe_result_if;
    logic        valid;
    logic        ready;
    logic [11:0] iteration_count;
    logic        escaped;

    modport source (output valid, output iteration_count, output escaped, input ready);
    modport sink   (input valid, input iteration_count, input escaped, output ready);
endinterface

interface mbe_cfg_if;
    logic        valid;
    logic        ready;
    logic [11:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: hdl/mbe_mul.sv
// shared unsigned multiplier, second operand taken one chunk per cycle while i_go is high
// depends on mbe_pkg
`timescale 1ns / 1ps

module mbe_mul #(
    parameter int MAG_W = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_go,
    input  logic [MAG_W-1:0]     i_a,
    input  logic [MAG_W-1:0]     i_b,
    output logic                 o_done,
    output logic [2*MAG_W-1:0]   o_prod
);
    import mbe_pkg::*;

    localparam int NCH   = (MAG_W + MUL_CHUNK - 1) / MUL_CHUNK;
    localparam int KW    = (NCH > 1) ? $clog2(NCH) : 1;
    localparam int BX_W  = NCH * MUL_CHUNK;
    localparam int ACC_W = MAG_W + BX_W;
    localparam int PP_W  = MAG_W + MUL_CHUNK;

    logic [KW-1:0]        r_k;
    logic [ACC_W-1:0]     r_acc;
    logic [BX_W-1:0]      w_bx;
    logic [MUL_CHUNK-1:0] w_chunk;
    logic [PP_W-1:0]      w_pp;
    logic [ACC_W-1:0]     w_sum;
    logic                 w_last;

    assign w_bx    = BX_W'(i_b);
    assign w_chunk = w_bx[r_k*MUL_CHUNK +: MUL_CHUNK];
    assign w_pp    = PP_W'(i_a) * PP_W'(w_chunk);
    assign w_last  = (r_k == KW'(NCH - 1));

    // first chunk starts from zero
    assign w_sum = ((r_k == '0) ? '0 : r_acc) + (ACC_W'(w_pp) << (MUL_CHUNK * r_k));

    assign o_done = i_go && w_last;
    assign o_prod = w_sum[2*MAG_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k <= '0;
        end else if (i_go) begin
            r_k <= w_last ? '0 : r_k + KW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_acc <= w_sum;
        end
    end

endmodule

// File: hdl/mbe_iter.sv
// iteration engine: sequencer, z registers and escape test around one multiplier
// depends on mbe_pkg and mbe_mul
`timescale 1ns / 1ps

module mbe_iter #(
    parameter int FRAC_BITS   = 28,
    parameter int COUNT_WIDTH = 12
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  mbe_pkg::t_iter_ctl                 i_ctl,
    input  logic signed [mbe_pkg::IN_W-1:0]    i_c_real,
    input  logic signed [mbe_pkg::IN_W-1:0]    i_c_imag,
    input  logic [COUNT_WIDTH-1:0]             i_limit,
    output mbe_pkg::t_iter_stat                o_stat,
    output mbe_pkg::t_iter_res                 o_res
);
    import mbe_pkg::*;

    localparam int Z_W    = FRAC_BITS + 5;        // signed z, |z| < 16
    localparam int MAG_W  = FRAC_BITS + 4;        // magnitude of z
    localparam int P_W    = 2 * MAG_W;            // one square
    localparam int UP     = (FRAC_BITS >= IN_FRAC) ? FRAC_BITS - IN_FRAC : 0;
    localparam int DN     = (FRAC_BITS <  IN_FRAC) ? IN_FRAC - FRAC_BITS : 0;
    localparam int EXT_W  = IN_W + UP;
    localparam logic [P_W:0] THRESH = (P_W + 1)'(1) << (2 * FRAC_BITS + ESC_LOG2);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MXX  = 3'd1;
    localparam logic [2:0] S_MYY  = 3'd2;
    localparam logic [2:0] S_MXY  = 3'd3;
    localparam logic [2:0] S_EVAL = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    logic [2:0]              r_state, n_state;
    logic [COUNT_WIDTH-1:0]  r_iter, n_iter;
    logic [COUNT_WIDTH-1:0]  r_limit, n_limit;
    logic signed [Z_W-1:0]   r_zx, n_zx, r_zy, n_zy;
    logic signed [Z_W-1:0]   r_cx, n_cx, r_cy, n_cy;
    logic [P_W-1:0]          r_sqx, n_sqx, r_sqy, n_sqy, r_xy, n_xy;
    logic [CNT_OUT_W-1:0]    r_count, n_count;
    logic                    r_esc, n_esc;

    logic signed [EXT_W-1:0] w_cx_ext, w_cy_ext;
    logic [MAG_W-1:0]        w_ax, w_ay, w_ma, w_mb;
    logic                    w_go, w_done;
    logic [P_W-1:0]          w_prod;
    logic [P_W:0]            w_mag2;
    logic signed [P_W:0]     w_diff;
    logic signed [P_W+1:0]   w_cross;
    logic                    w_escape;

    // input scaling to FRAC_BITS fraction bits, right shift floors
    assign w_cx_ext = (EXT_W'(i_c_real) <<< UP) >>> DN;
    assign w_cy_ext = (EXT_W'(i_c_imag) <<< UP) >>> DN;

    assign w_ax = r_zx[Z_W-1] ? MAG_W'(-r_zx) : MAG_W'(r_zx);
    assign w_ay = r_zy[Z_W-1] ? MAG_W'(-r_zy) : MAG_W'(r_zy);

    // operand select for the shared multiplier
    always_comb begin
        unique case (r_state)
            S_MXX:   begin w_ma = w_ax; w_mb = w_ax; end
            S_MYY:   begin w_ma = w_ay; w_mb = w_ay; end
            default: begin w_ma = w_ax; w_mb = w_ay; end
        endcase
    end

    assign w_go = (r_state == S_MXX) || (r_state == S_MYY) || (r_state == S_MXY);

    mbe_mul #(
        .MAG_W (MAG_W)
    ) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (w_go),
        .i_a     (w_ma),
        .i_b     (w_mb),
        .o_done  (w_done),
        .o_prod  (w_prod)
    );

    // squares of the current z double as the escape test of the last update
    assign w_mag2   = (P_W + 1)'(r_sqx) + (P_W + 1)'(r_sqy);
    assign w_escape = (r_iter != '0) && (w_mag2 > THRESH);
    assign w_diff   = $signed({1'b0, r_sqx}) - $signed({1'b0, r_sqy});
    assign w_cross  = (r_zx[Z_W-1] ^ r_zy[Z_W-1]) ? -$signed({1'b0, r_xy, 1'b0})
                                                  :  $signed({1'b0, r_xy, 1'b0});

    always_comb begin
        n_state = r_state;
        n_iter  = r_iter;
        n_limit = r_limit;
        n_zx    = r_zx;
        n_zy    = r_zy;
        n_cx    = r_cx;
        n_cy    = r_cy;
        n_sqx   = r_sqx;
        n_sqy   = r_sqy;
        n_xy    = r_xy;
        n_count = r_count;
        n_esc   = r_esc;
        unique case (r_state)
            S_IDLE: begin
                if (i_ctl.start) begin
                    n_cx    = Z_W'(w_cx_ext);
                    n_cy    = Z_W'(w_cy_ext);
                    n_zx    = '0;
                    n_zy    = '0;
                    n_iter  = '0;
                    n_limit = i_limit;
                    n_state = S_MXX;
                end
            end
            S_MXX: begin
                if (w_done) begin
                    n_sqx   = w_prod;
                    n_state = S_MYY;
                end
            end
            S_MYY: begin
                if (w_done) begin
                    n_sqy   = w_prod;
                    n_state = S_MXY;
                end
            end
            S_MXY: begin
                if (w_done) begin
                    n_xy    = w_prod;
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                priority if (w_escape) begin
                    n_count = CNT_OUT_W'(r_iter - COUNT_WIDTH'(1));
                    n_esc   = 1'b1;
                    n_state = S_DONE;
                end else if (r_iter == r_limit) begin
                    n_count = '0;
                    n_esc   = 1'b0;
                    n_state = S_DONE;
                end else begin
                    n_zx    = Z_W'(w_diff >>> FRAC_BITS) + r_cx;
                    n_zy    = Z_W'(w_cross >>> FRAC_BITS) + r_cy;
                    n_iter  = r_iter + COUNT_WIDTH'(1);
                    n_state = S_MXX;
                end
            end
            S_DONE: begin
                if (i_ctl.take) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_iter  <= n_iter;
        r_limit <= n_limit;
        r_zx    <= n_zx;
        r_zy    <= n_zy;
        r_cx    <= n_cx;
        r_cy    <= n_cy;
        r_sqx   <= n_sqx;
        r_sqy   <= n_sqy;
        r_xy    <= n_xy;
        r_count <= n_count;
        r_esc   <= n_esc;
    end

    assign o_stat.idle      = (r_state == S_IDLE);
    assign o_stat.res_valid = (r_state == S_DONE);
    assign o_res.count      = r_count;
    assign o_res.escaped    = r_esc;

endmodule

// File: hdl/mandelbrot_escape_time_core.sv
// mandelbrot escape-time core: config register, point intake, result register
// depends on mbe_pkg, mbe_if, mbe_iter (which holds mbe_mul)
// throughput: one point at a time, set by the single shared multiplier that forms
//   zx*zx, zy*zy and zx*zy in turn each iteration; engine ready for the next point the cycle after hand-off
// reset: synchronous active-low, engine idle, output empty, max_iterations back to 550
`timescale 1ns / 1ps

module mandelbrot_escape_time_core #(
    parameter int FRAC_BITS   = 28,
    parameter int COUNT_WIDTH = 12
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    mbe_cfg_if.sink       i_cfg,
    mbe_point_if.sink     i_point,
    mbe_result_if.source  o_result
);
    import mbe_pkg::*;

    // only the low COUNT_WIDTH bits of the limit take part
    localparam int LIM_W = (COUNT_WIDTH < CFG_W) ? COUNT_WIDTH : CFG_W;

    logic [CFG_W-1:0]       r_max_iter;
    logic [COUNT_WIDTH-1:0] w_limit;

    logic                   r_out_valid;
    logic [CNT_OUT_W-1:0]   r_out_count;
    logic                   r_out_esc;

    t_iter_ctl              w_ctl;
    t_iter_stat             w_stat;
    t_iter_res              w_res;
    logic                   w_take;

    // configuration: always ready, the engine latches the limit when a point starts
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_iter <= RESET_ITERATIONS;
        end else if (i_cfg.valid) begin
            r_max_iter <= i_cfg.data;
        end
    end

    assign w_limit = COUNT_WIDTH'(r_max_iter[LIM_W-1:0]);

    // point intake: a transaction starts the engine when it is idle
    assign i_point.ready = w_stat.idle;

    // result hand-off into the output register when it is empty or draining
    assign w_take    = w_stat.res_valid && (!r_out_valid || o_result.ready);
    assign w_ctl.start = i_point.valid && w_stat.idle;
    assign w_ctl.take  = w_take;

    mbe_iter #(
        .FRAC_BITS   (FRAC_BITS),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_iter (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_ctl),
        .i_c_real (i_point.c_real),
        .i_c_imag (i_point.c_imag),
        .i_limit  (w_limit),
        .o_stat   (w_stat),
        .o_res    (w_res)
    );

    // output register parts the engine from the downstream stall
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_take) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_out_count <= w_res.count;
            r_out_esc   <= w_res.escaped;
        end
    end

    assign o_result.valid           = r_out_valid;
    assign o_result.iteration_count = r_out_count;
    assign o_result.escaped         = r_out_esc;

    // a started point keeps the engine busy on the next cycle
    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_point.valid && i_point.ready |=> !i_point.ready)
        else $error("engine ready right after taking a point");

    // a point that stays inside reports a zero count
    a_inside_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid && !o_result.escaped |-> o_result.iteration_count == '0)
        else $error("nonzero count on a non-escaped result");

    // a finished result waits in the engine until the output register takes it
    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.res_valid && !w_take |=> w_stat.res_valid)
        else $error("finished result dropped before hand-off");

endmodule
